// File: design/gbn_pkg.sv
package gbn_pkg;

   localparam int WINDOW    = 8;
   localparam int SEQ_BITS  = 8;
   localparam int SEQ_MASK  = (1 << SEQ_BITS) - 1;
   localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_BITS  = $clog2(WINDOW + 1);

   localparam int WIN_BITS  = 4;
   localparam int TMO_BITS  = 16;
   localparam int CSR_BITS  = 16;

   typedef enum logic [1:0] {
      MODE_OFFER = 2'd0,
      MODE_ACK   = 2'd1,
      MODE_TICK  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_SEND    = 2'd0,
      KIND_RESEND  = 2'd1,
      KIND_REFUSED = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_WINDOW  = 1'b0,
      CSR_TIMEOUT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] payload;
      logic [7:0]  ack_seq;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  frame_seq;
      logic [31:0] frame_payload;
      logic        last;
   } rsp_type;

endpackage

// File: design/gbn_ram.sv
module gbn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [ABITS-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [ABITS-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/go_back_n_sender.sv
// Go-Back-N sender window. Each input word is an offer (mode 0), a cumulative
// ack (mode 1) or a timer tick (mode 2). An offer is answered next cycle
// by a single first-send or refused word; acks and ticks produce no output
// unless a tick expires the timer, in which case every outstanding frame is
// resent in order from the frame store, each word by a store read and then
// an output register load that waits out a stall; input is stalled until
// the last resend is loaded. Otherwise input is taken while the output is
// free. Configuration registers must be written only while idle.
module go_back_n_sender
   import gbn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_word,
   input  logic                csr_we,
   input  csr_index_type       csr_index,
   input  logic [CSR_BITS-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [SEQ_BITS-1:0]   base_ff, base_in;
   logic [SEQ_BITS-1:0]   next_ff, next_in;
   logic [TMO_BITS-1:0]   timer_ff, timer_in;
   logic                  running_ff, running_in;
   logic [WIN_BITS-1:0]   win_ff, win_in;
   logic [TMO_BITS-1:0]   tmo_ff, tmo_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic [CNT_BITS-1:0]   burst_ff, burst_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_word_ff, rsp_word_in;

   logic [WIN_BITS-1:0]   eff_win;
   logic [TMO_BITS-1:0]   eff_tmo;
   logic [SEQ_BITS-1:0]   outstanding;
   logic [SEQ_BITS-1:0]   ack;
   logic [SEQ_BITS-1:0]   ack_dist;
   logic [SEQ_BITS-1:0]   ack_next;
   logic [SEQ_BITS-1:0]   rs_seq;
   logic [TMO_BITS-1:0]   timer_dec;
   logic                  out_free;
   logic                  req_acc;
   logic                  burst_last;

   logic                  ram_we;
   logic [SLOT_BITS-1:0]  ram_waddr;
   logic                  ram_re;
   logic [SLOT_BITS-1:0]  ram_raddr;
   logic [31:0]           ram_rdata;

   gbn_ram #(
      .WIDTH (32),
      .DEPTH (WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_word.payload),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      eff_win = win_ff;
      if (eff_win == '0) begin
         eff_win = WIN_BITS'(1);
      end
      if (int'(eff_win) > WINDOW) begin
         eff_win = WIN_BITS'(WINDOW);
      end
      if (int'(eff_win) > SEQ_MASK) begin
         eff_win = WIN_BITS'(SEQ_MASK);
      end
   end

   assign eff_tmo     = (tmo_ff == '0) ? TMO_BITS'(1) : tmo_ff;
   assign outstanding = next_ff - base_ff;
   assign ack         = SEQ_BITS'(req_word.ack_seq);
   assign ack_dist    = ack - base_ff;
   assign ack_next    = ack + SEQ_BITS'(1);
   assign rs_seq      = base_ff + SEQ_BITS'(idx_ff);
   assign timer_dec   = (timer_ff != '0) ? timer_ff - TMO_BITS'(1) : timer_ff;
   assign burst_last  = (CNT_BITS'(idx_ff + CNT_BITS'(1)) == burst_ff);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_acc   = req_valid && !req_stall;

   assign ram_waddr = SLOT_BITS'(next_ff % WINDOW);
   assign ram_raddr = SLOT_BITS'(rs_seq % WINDOW);
   assign ram_re    = (state_ff == ST_READ);

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      timer_in     = timer_ff;
      running_in   = running_ff;
      win_in       = win_ff;
      tmo_in       = tmo_ff;
      idx_in       = idx_ff;
      burst_in     = burst_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW:  win_in = csr_wdata[WIN_BITS-1:0];
            CSR_TIMEOUT: tmo_in = csr_wdata[TMO_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (mode_type'(req_word.mode))
                  MODE_OFFER: begin
                     rsp_valid_in            = 1'b1;
                     rsp_word_in.frame_seq   = 8'(next_ff);
                     rsp_word_in.last        = 1'b1;
                     if (outstanding >= SEQ_BITS'(eff_win)) begin
                        rsp_word_in.kind          = KIND_REFUSED;
                        rsp_word_in.frame_payload = '0;
                     end else begin
                        ram_we                    = 1'b1;
                        rsp_word_in.kind          = KIND_SEND;
                        rsp_word_in.frame_payload = req_word.payload;
                        next_in                   = next_ff + SEQ_BITS'(1);
                        if (outstanding == '0) begin
                           timer_in   = eff_tmo;
                           running_in = 1'b1;
                        end
                     end
                  end
                  MODE_ACK: begin
                     if (ack_dist < outstanding) begin
                        base_in = ack_next;
                        if (ack_next == next_ff) begin
                           running_in = 1'b0;
                           timer_in   = '0;
                        end else begin
                           running_in = 1'b1;
                           timer_in   = eff_tmo;
                        end
                     end
                  end
                  MODE_TICK: begin
                     if (running_ff) begin
                        timer_in = timer_dec;
                        if (timer_dec == '0) begin
                           if (outstanding == '0) begin
                              running_in = 1'b0;
                           end else begin
                              timer_in = eff_tmo;
                              idx_in   = '0;
                              if (int'(outstanding) > WINDOW) begin
                                 burst_in = CNT_BITS'(WINDOW);
                              end else begin
                                 burst_in = CNT_BITS'(outstanding);
                              end
                              state_in = ST_READ;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.kind          = KIND_RESEND;
               rsp_word_in.frame_seq     = 8'(rs_seq);
               rsp_word_in.frame_payload = ram_rdata;
               rsp_word_in.last          = burst_last;
               idx_in                    = CNT_BITS'(idx_ff + CNT_BITS'(1));
               state_in                  = burst_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         next_ff      <= '0;
         timer_ff     <= '0;
         running_ff   <= 1'b0;
         win_ff       <= WIN_BITS'(2);
         tmo_ff       <= TMO_BITS'(3);
         idx_ff       <= '0;
         burst_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         timer_ff     <= timer_in;
         running_ff   <= running_in;
         win_ff       <= win_in;
         tmo_ff       <= tmo_in;
         idx_ff       <= idx_in;
         burst_ff     <= burst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: design/go_back_n_sender_checker.sv
module go_back_n_sender_checker
   import gbn_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_word,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled word changed");

   a_offer_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_word.mode == MODE_OFFER |=>
         rsp_valid && rsp_word.last &&
         (rsp_word.kind == KIND_SEND || rsp_word.kind == KIND_REFUSED))
      else $error("offer not answered next cycle");

   a_burst_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_word.kind == KIND_RESEND && !rsp_word.last
         |-> req_stall)
      else $error("input taken during resend burst");

   a_refused_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.kind == KIND_REFUSED |->
         rsp_word.frame_payload == '0 && rsp_word.last)
      else $error("refused word malformed");

endmodule

bind go_back_n_sender go_back_n_sender_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
